// File: rtl/core/mcg_pkg.sv
// Shared constants and control/status types for the midpoint circle generator.
// No dependencies; used by mcg_ctrl, mcg_dp and midpoint_circle_generator_core.
package mcg_pkg;

  // Default field widths
  localparam int DEF_COORD_WIDTH  = 11;
  localparam int DEF_RADIUS_WIDTH = 6;

  // Results per circle are capped at this count
  localparam int MAX_RESULTS = 46;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Controller -> datapath commands
  typedef struct packed {
    logic load;   // capture a new request
    logic emit;   // register one result; advance the walk unless it is the final one
  } mcg_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic more;   // the current result is not the final one
  } mcg_sts_t;

endpackage

// File: rtl/core/mcg_ctrl.sv
// Controller for the midpoint circle generator: idle/run sequencing and output valid.
// Depends on mcg_pkg for command and status types.
module mcg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mcg_pkg::mcg_cmd_t cmd,
  input  mcg_pkg::mcg_sts_t sts
);
  import mcg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Output register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // Commands
  always_comb begin
    cmd.load = (state_r == ST_IDLE) && in_valid;
    cmd.emit = (state_r == ST_RUN) && out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (out_free && !sts.more) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on emit, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r == ST_RUN);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/mcg_dp.sv
// Datapath for the midpoint circle generator: x/y/decision walk and result register.
// Depends on mcg_pkg for command/status types and the result cap.
module mcg_dp #(
  parameter int COORD_WIDTH  = mcg_pkg::DEF_COORD_WIDTH,
  parameter int RADIUS_WIDTH = mcg_pkg::DEF_RADIUS_WIDTH
) (
  input  logic                           clk,
  input  mcg_pkg::mcg_cmd_t              cmd,
  output mcg_pkg::mcg_sts_t              sts,
  input  logic signed [COORD_WIDTH-1:0]  in_center_x,
  input  logic signed [COORD_WIDTH-1:0]  in_center_y,
  input  logic        [RADIUS_WIDTH-1:0] in_radius,
  output logic signed [COORD_WIDTH:0]    out_px_pos_x,
  output logic signed [COORD_WIDTH:0]    out_px_neg_x,
  output logic signed [COORD_WIDTH:0]    out_px_pos_y,
  output logic signed [COORD_WIDTH:0]    out_px_neg_y,
  output logic signed [COORD_WIDTH:0]    out_py_pos_y,
  output logic signed [COORD_WIDTH:0]    out_py_neg_y,
  output logic signed [COORD_WIDTH:0]    out_py_pos_x,
  output logic signed [COORD_WIDTH:0]    out_py_neg_x,
  output logic                           out_last_step
);
  import mcg_pkg::*;

  localparam int OW = COORD_WIDTH + 1;
  localparam int DW = RADIUS_WIDTH + 4;   // decision stays within a few radii

  // Walk state and held center
  logic [COORD_WIDTH-1:0]  cx_r, cy_r;
  logic [RADIUS_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [DW-1:0]           d_r, d_nxt, delta;
  logic [CNT_W-1:0]        n_r, n_nxt;

  // Result register
  logic [OW-1:0] pxpx_r, pxnx_r, pxpy_r, pxny_r, pypy_r, pyny_r, pypx_r, pynx_r;
  logic          last_r;

  logic [OW-1:0] hx, ky, xo, yo;
  logic          more;

  // Widen center (signed) and offsets (unsigned) to the result width
  assign hx = {cx_r[COORD_WIDTH-1], cx_r};
  assign ky = {cy_r[COORD_WIDTH-1], cy_r};
  assign xo = OW'(x_r);
  assign yo = OW'(y_r);

  // Loop continues while y > x and below the result cap
  assign more     = (y_r > x_r) && (n_r < CNT_W'(MAX_RESULTS - 1));
  assign sts.more = more;

  // Decision step: 2x+3 when negative, else 2(x-y)+5 with y stepping down
  always_comb begin
    y_nxt = y_r;
    if (d_r[DW-1]) begin
      delta = DW'({x_r, 1'b0}) + DW'(3);
    end else begin
      delta = DW'({x_r, 1'b0}) - DW'({y_r, 1'b0}) + DW'(5);
      y_nxt = y_r - RADIUS_WIDTH'(1);
    end
    d_nxt = d_r + delta;
    x_nxt = x_r + RADIUS_WIDTH'(1);
    n_nxt = n_r + CNT_W'(1);
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      x_r  <= '0;
      y_r  <= in_radius;
      d_r  <= DW'(1) - DW'(in_radius);
      n_r  <= '0;
    end else if (cmd.emit && more) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      d_r <= d_nxt;
      n_r <= n_nxt;
    end
  end

  // Result register: eight symmetric sums and the final flag
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pxpx_r <= hx + xo;
      pxnx_r <= hx - xo;
      pxpy_r <= hx + yo;
      pxny_r <= hx - yo;
      pypy_r <= ky + yo;
      pyny_r <= ky - yo;
      pypx_r <= ky + xo;
      pynx_r <= ky - xo;
      last_r <= !more;
    end
  end

  assign out_px_pos_x  = pxpx_r;
  assign out_px_neg_x  = pxnx_r;
  assign out_px_pos_y  = pxpy_r;
  assign out_px_neg_y  = pxny_r;
  assign out_py_pos_y  = pypy_r;
  assign out_py_neg_y  = pyny_r;
  assign out_py_pos_x  = pypx_r;
  assign out_py_neg_x  = pynx_r;
  assign out_last_step = last_r;

endmodule

// File: rtl/core/midpoint_circle_generator_core.sv
// Midpoint circle generator top level: controller plus datapath.
// Depends on mcg_pkg, mcg_ctrl and mcg_dp.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | center_x, center_y, radius
//   out_    | output    | out_valid / out_stall | eight octant sums, last_step
//
// A request is taken, then one result is registered per cycle unless out_stall
// holds the output, one per step of the x/y/decision walk; radius 0 gives one
// result.
// in_stall is high from acceptance until the final result is registered; the
// next request can be taken while that result still waits at the output.
// out_stall holds the result register and pauses the walk.
// Synchronous active-low reset returns to idle with no result pending.
module midpoint_circle_generator_core #(
  parameter int COORD_WIDTH  = mcg_pkg::DEF_COORD_WIDTH,
  parameter int RADIUS_WIDTH = mcg_pkg::DEF_RADIUS_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_WIDTH-1:0]  in_center_x,
  input  logic signed [COORD_WIDTH-1:0]  in_center_y,
  input  logic        [RADIUS_WIDTH-1:0] in_radius,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_WIDTH:0]    out_px_pos_x,
  output logic signed [COORD_WIDTH:0]    out_px_neg_x,
  output logic signed [COORD_WIDTH:0]    out_px_pos_y,
  output logic signed [COORD_WIDTH:0]    out_px_neg_y,
  output logic signed [COORD_WIDTH:0]    out_py_pos_y,
  output logic signed [COORD_WIDTH:0]    out_py_neg_y,
  output logic signed [COORD_WIDTH:0]    out_py_pos_x,
  output logic signed [COORD_WIDTH:0]    out_py_neg_x,
  output logic                           out_last_step
);
  import mcg_pkg::*;

  mcg_cmd_t cmd;
  mcg_sts_t sts;

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcg_dp #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius     (in_radius),
    .out_px_pos_x  (out_px_pos_x),
    .out_px_neg_x  (out_px_neg_x),
    .out_px_pos_y  (out_px_pos_y),
    .out_px_neg_y  (out_px_neg_y),
    .out_py_pos_y  (out_py_pos_y),
    .out_py_neg_y  (out_py_neg_y),
    .out_py_pos_x  (out_py_pos_x),
    .out_py_neg_x  (out_py_neg_x),
    .out_last_step (out_last_step)
  );

  // An accepted request keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request transaction");

  // A non-final result can only be delivered while the circle is still running
  a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_step |-> in_stall)
    else $error("non-final result delivered while idle");

  // Load and emit are never issued together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.emit))
    else $error("load and emit issued in the same cycle");

endmodule
